// ===== design/gccf_pkg.sv =====
// ----------------------------------------------------------------------------
// gccf_pkg
// Shared types and constants of the greedy colored clique finder.
// ----------------------------------------------------------------------------
`default_nettype none
package gccf_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VertexBits  = 6;
  localparam int unsigned CountBits   = 7;
  localparam int unsigned ColorBits   = 8;
  localparam int unsigned DegBits     = 7;

  localparam logic [1:0] ReqClear   = 2'd0;
  localparam logic [1:0] ReqColor   = 2'd1;
  localparam logic [1:0] ReqEdge    = 2'd2;
  localparam logic [1:0] ReqCompute = 2'd3;

  typedef enum logic [2:0] {
    CellNop,
    CellClear,
    CellSetColor,
    CellAddEdge,
    CellCandInit,
    CellCandUpdate
  } cell_op_e;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [VertexBits-1:0] vertex_a;
    logic [VertexBits-1:0] vertex_b;
    logic [7:0]            color;
  } in_item_t;

  typedef struct packed {
    logic [VertexBits-1:0] vertex;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    cell_op_e              op;
    logic [VertexBits-1:0] a;
    logic [VertexBits-1:0] b;
    logic [ColorBits-1:0]  color;
    logic [CountBits-1:0]  n;
    logic                  diff;
    logic [VertexBits-1:0] best;
    logic [ColorBits-1:0]  best_color;
  } cell_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [DegBits-1:0]    deg;
    logic [VertexBits-1:0] idx;
    logic [ColorBits-1:0]  color;
  } token_t;

  typedef struct packed {
    logic                 hit;
    logic [ColorBits-1:0] color_a;
    logic [ColorBits-1:0] color_b;
  } lookup_t;

endpackage
`default_nettype wire

// ===== design/gccf_cell.sv =====
// ----------------------------------------------------------------------------
// gccf_cell
// One vertex: adjacency row, degree, color and candidate bit, plus one stage
// of the running best-vertex chain.
// ----------------------------------------------------------------------------
`default_nettype none
module gccf_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [gccf_pkg::VertexBits-1:0] idx_i,
  input  wire gccf_pkg::cell_cmd_t             cmd_i,
  input  wire gccf_pkg::token_t                tok_i,
  output gccf_pkg::token_t                     tok_o,
  output gccf_pkg::lookup_t                    look_o
);

  logic [gccf_pkg::MaxVertices-1:0] adj_q, adj_d;
  logic [gccf_pkg::DegBits-1:0]     deg_q, deg_d;
  logic [gccf_pkg::ColorBits-1:0]   color_q, color_d;
  logic                             cand_q, cand_d;
  gccf_pkg::token_t                 tok_q, tok_d;
  logic                             sel_a, sel_b, in_range;

  assign sel_a    = (idx_i == cmd_i.a);
  assign sel_b    = (idx_i == cmd_i.b);
  assign in_range = ({1'b0, idx_i} < cmd_i.n);

  always_comb begin
    adj_d   = adj_q;
    deg_d   = deg_q;
    color_d = color_q;
    cand_d  = cand_q;
    unique case (cmd_i.op)
      gccf_pkg::CellClear: begin
        adj_d = '0;
        deg_d = '0;
      end
      gccf_pkg::CellSetColor: begin
        if (sel_a) color_d = cmd_i.color;
      end
      gccf_pkg::CellAddEdge: begin
        if (sel_a) adj_d[cmd_i.b] = 1'b1;
        if (sel_b) adj_d[cmd_i.a] = 1'b1;
        if ((sel_a || sel_b) && cmd_i.diff) deg_d = deg_q + 1'b1;
      end
      gccf_pkg::CellCandInit: begin
        cand_d = in_range;
      end
      gccf_pkg::CellCandUpdate: begin
        cand_d = cand_q && adj_q[cmd_i.best] && (color_q != cmd_i.best_color) &&
                 (idx_i != cmd_i.best);
      end
      default: ;
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    if (cand_q && (!tok_i.valid || (deg_q > tok_i.deg))) begin
      tok_d.valid = 1'b1;
      tok_d.deg   = deg_q;
      tok_d.idx   = idx_i;
      tok_d.color = color_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q   <= '0;
      deg_q   <= '0;
      color_q <= '0;
      cand_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      adj_q   <= adj_d;
      deg_q   <= deg_d;
      color_q <= color_d;
      cand_q  <= cand_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o          = tok_q;
  assign look_o.hit     = sel_a && adj_q[cmd_i.b];
  assign look_o.color_a = sel_a ? color_q : '0;
  assign look_o.color_b = sel_b ? color_q : '0;

endmodule
`default_nettype wire

// ===== design/greedy_colored_clique_finder.sv =====
// ----------------------------------------------------------------------------
// greedy_colored_clique_finder
// Holds a colored graph in a row of vertex cells and grows a clique greedily.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_i  (in_item_t)
// out       output     out_valid_o / out_stall_i  out_o (out_item_t)
// cfg       input      cfg_we_i                   cfg_data_i (vertex count)
//
// Clear and set color act when the request is taken; add edge first looks the edge up in SLook.
// A compute runs one pass through the cell chain per clique member plus one more to find the end.
// Reset clears the whole graph at once; no input is taken during a compute.
// A stalled output transfer holds the compute until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module greedy_colored_clique_finder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire gccf_pkg::in_item_t             in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output gccf_pkg::out_item_t                 out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [gccf_pkg::CountBits-1:0] cfg_data_i
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLook = 2'd1;
  localparam logic [1:0] SWave = 2'd2;
  localparam logic [1:0] SDone = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [gccf_pkg::CountBits-1:0]  vc_q;
  logic [gccf_pkg::CountBits-1:0]  n;
  gccf_pkg::in_item_t              req_q;
  logic [gccf_pkg::VertexBits-1:0] cnt_q, cnt_d;
  logic                            pend_v_q, pend_v_d;
  logic [gccf_pkg::VertexBits-1:0] pend_q, pend_d;
  logic                            out_v_q, out_v_d;
  gccf_pkg::out_item_t             out_q, out_d;
  gccf_pkg::cell_cmd_t             cmd;
  gccf_pkg::token_t                tok [gccf_pkg::MaxVertices+1];
  gccf_pkg::lookup_t               look [gccf_pkg::MaxVertices];
  logic                            hit;
  logic [gccf_pkg::ColorBits-1:0]  col_a, col_b;
  logic                            accept, can_out;

  always_comb begin
    if (vc_q == '0) n = gccf_pkg::CountBits'(1);
    else if (vc_q > gccf_pkg::CountBits'(gccf_pkg::MaxVertices))
      n = gccf_pkg::CountBits'(gccf_pkg::MaxVertices);
    else n = vc_q;
  end

  assign tok[0] = '0;

  for (genvar i = 0; i < gccf_pkg::MaxVertices; i++) begin : g_cell
    gccf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (gccf_pkg::VertexBits'(i)),
      .cmd_i  (cmd),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .look_o (look[i])
    );
  end

  always_comb begin
    hit   = 1'b0;
    col_a = '0;
    col_b = '0;
    for (int i = 0; i < gccf_pkg::MaxVertices; i++) begin
      hit   = hit | look[i].hit;
      col_a = col_a | look[i].color_a;
      col_b = col_b | look[i].color_b;
    end
  end

  assign accept  = in_valid_i && (state_q == SIdle);
  assign can_out = !out_v_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    cmd            = '0;
    cmd.op         = gccf_pkg::CellNop;
    cmd.n          = n;
    cmd.a          = accept ? in_i.vertex_a : req_q.vertex_a;
    cmd.b          = accept ? in_i.vertex_b : req_q.vertex_b;
    cmd.color      = in_i.color[gccf_pkg::ColorBits-1:0];
    cmd.diff       = (col_a != col_b);
    cmd.best       = tok[gccf_pkg::MaxVertices].idx;
    cmd.best_color = tok[gccf_pkg::MaxVertices].color;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (in_i.req_type)
            gccf_pkg::ReqClear: cmd.op = gccf_pkg::CellClear;
            gccf_pkg::ReqColor: begin
              if ({1'b0, in_i.vertex_a} < n) cmd.op = gccf_pkg::CellSetColor;
            end
            gccf_pkg::ReqEdge: state_d = SLook;
            gccf_pkg::ReqCompute: begin
              cmd.op   = gccf_pkg::CellCandInit;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              state_d  = SWave;
            end
            default: ;
          endcase
        end
      end
      SLook: begin
        if (({1'b0, req_q.vertex_a} < n) && ({1'b0, req_q.vertex_b} < n) && !hit)
          cmd.op = gccf_pkg::CellAddEdge;
        state_d = SIdle;
      end
      SWave: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == gccf_pkg::VertexBits'(gccf_pkg::MaxVertices - 1)) state_d = SDone;
      end
      SDone: begin
        if (can_out) begin
          if (tok[gccf_pkg::MaxVertices].valid) begin
            if (pend_v_q) begin
              out_v_d      = 1'b1;
              out_d.vertex = pend_q;
              out_d.last   = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = tok[gccf_pkg::MaxVertices].idx;
            cmd.op   = gccf_pkg::CellCandUpdate;
            cnt_d    = '0;
            state_d  = SWave;
          end else begin
            out_v_d      = 1'b1;
            out_d.vertex = pend_q;
            out_d.last   = 1'b1;
            pend_v_d     = 1'b0;
            state_d      = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      vc_q     <= gccf_pkg::CountBits'(gccf_pkg::MaxVertices);
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) vc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_i;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire
